/* rtl/mcsps_pkg.sv */
// Package for the servo pulse sequencer: constants, command codes, queue entry type.
// No dependencies.
`timescale 1ns / 1ps
package mcsps_pkg;
  localparam int CHANNELS = 8;
  localparam int CH_W = 3;
  localparam int MIN_PULSE_US = 544;
  localparam int MAX_PULSE_US = 2400;
  localparam int DEFAULT_PULSE_US = 1500;
  localparam int IN_W = 64;   // 59 bits of fields, padded to bytes
  localparam int OUT_W = 32;  // 30 bits of fields, padded to bytes
  // ceil(2^23 / 45): x / 180 == ((x >> 2) * RECIP45) >> 23 for x < 2^20
  localparam logic [17:0] RECIP45 = 18'd186414;

  typedef enum logic [2:0] {
    OP_ATTACH  = 3'd0,
    OP_DETACH  = 3'd1,
    OP_ANGLE   = 3'd2,
    OP_US      = 3'd3,
    OP_COMPARE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_REFRESH = 2'd0,
    REG_TRIM    = 2'd1,
    REG_CPU     = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CALC, ST_DIV, ST_TICK, ST_DONE
  } bk_state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  channel;
    logic        auto_channel;
    logic [11:0] min_us;
    logic [11:0] max_us;
    logic [11:0] value;
    logic [15:0] timer_count;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  assigned_channel;
    logic        low_valid;
    logic [2:0]  low_channel;
    logic        high_valid;
    logic [2:0]  high_channel;
    logic        compare_valid;
    logic [15:0] compare_value;
    logic        frame_underflow;
  } res_t;

  // Quantized limit: param - 4*clamp(trunc((param-req)/4), -127, 127).
  function automatic logic [11:0] quantize(input logic [11:0] param, input logic [11:0] req);
    logic signed [13:0] d;
    logic [13:0] mag;
    logic signed [13:0] step;
    logic signed [13:0] lim;
    d = $signed({2'b00, param}) - $signed({2'b00, req});
    mag = d[13] ? 14'(-d) : 14'(d);
    mag = mag >> 2;
    if (mag > 14'd127) mag = 14'd127;
    step = d[13] ? 14'(-$signed(mag)) : $signed(mag);
    lim = $signed({2'b00, param}) - (step <<< 2);
    return lim[11:0];
  endfunction
endpackage

/* rtl/mcsps_queue.sv */
// Two-entry command queue between the front end and the execution engine.
// Depends on mcsps_pkg.
`timescale 1ns / 1ps
module mcsps_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  mcsps_pkg::cmd_t    wr_data,
  output logic               rd_valid,
  input  logic               rd_ready,
  output mcsps_pkg::cmd_t    rd_data
);
  mcsps_pkg::cmd_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* rtl/mcsps_front.sv */
// Front end: unpacks input items into commands; unknown operations pass through.
// Depends on mcsps_pkg.
`timescale 1ns / 1ps
module mcsps_front (
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [mcsps_pkg::IN_W-1:0] in_tdata,
  output logic                       q_valid,
  input  logic                       q_ready,
  output mcsps_pkg::cmd_t            q_data
);
  // Unknown operations still pass: the back end answers them with zeros.
  assign q_data.op           = in_tdata[2:0];
  assign q_data.channel      = in_tdata[5:3];
  assign q_data.auto_channel = in_tdata[6];
  assign q_data.min_us       = in_tdata[18:7];
  assign q_data.max_us       = in_tdata[30:19];
  assign q_data.value        = in_tdata[42:31];
  assign q_data.timer_count  = in_tdata[58:43];
  assign q_valid   = in_tvalid;
  assign in_tready = q_ready;
endmodule

/* rtl/mcsps_back.sv */
// Execution engine: channel table, angle map, tick conversion, slot sequencing.
// Depends on mcsps_pkg.
`timescale 1ns / 1ps
module mcsps_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       refresh_r,
  input  logic [5:0]        trim_r,
  input  logic [7:0]        cpu_r,
  input  logic              q_valid,
  output logic              q_ready,
  input  mcsps_pkg::cmd_t   q_data,
  output logic              res_valid,
  input  logic              res_ready,
  output mcsps_pkg::res_t   res_data
);
  localparam int CN = mcsps_pkg::CHANNELS;

  logic [CN-1:0] active_r;
  logic [11:0]   min_r   [CN];
  logic [11:0]   max_r   [CN];
  logic [15:0]   ticks_r [CN];
  logic [18:0]   total_r;
  logic          idle_slot_r;
  logic [2:0]    slot_r;

  mcsps_pkg::bk_state_t st_r, st_nxt;
  mcsps_pkg::cmd_t cmd_r;
  mcsps_pkg::res_t res_r;
  mcsps_pkg::res_t out_r;
  logic            ovalid_r;

  // Angle datapath.
  logic [19:0]        num_r;     // a*(hi-lo) < 2^20
  logic [11:0]        quo_r;
  logic               div_first_r;
  logic [12:0]        us_r;      // microseconds after angle map / clamp
  logic [31:0]        prod_r;

  logic [2:0] ch;
  assign ch = cmd_r.channel;

  // First free channel and next active slot.
  logic       free_found;
  logic [2:0] free_ch;
  logic       next_found;
  logic [2:0] next_ch;
  always_comb begin
    free_found = 1'b0; free_ch = 3'd0;
    for (int i = CN - 1; i >= 0; i--)
      if (!active_r[i]) begin free_found = 1'b1; free_ch = 3'(i); end
    next_found = 1'b0; next_ch = 3'd0;
    for (int i = CN - 1; i >= 0; i--)
      if (active_r[i] && (idle_slot_r || 3'(i) > slot_r) && !(!idle_slot_r && slot_r == 3'd7))
        begin next_found = 1'b1; next_ch = 3'(i); end
  end

  logic [2:0]  att_ch;
  logic        att_ok;
  assign att_ch = cmd_r.auto_channel ? free_ch : ch;
  assign att_ok = cmd_r.auto_channel ? free_found : 1'b1;

  // Tick conversion from us_r (after clamp and trim).
  logic [12:0] lo13, hi13, clamped, trimmed;
  assign lo13 = {1'b0, min_r[ch]};
  assign hi13 = {1'b0, max_r[ch]};
  always_comb begin
    if (us_r < lo13) clamped = lo13;
    else if (us_r > hi13) clamped = hi13;
    else clamped = us_r;
    trimmed = (clamped > {7'd0, trim_r}) ? clamped - {7'd0, trim_r} : 13'd0;
  end
  logic [31:0] ticks_raw;
  logic [15:0] new_ticks;
  assign ticks_raw = (prod_r + 32'd4) >> 3;
  assign new_ticks = (ticks_raw > 32'd65535) ? 16'hFFFF : ticks_raw[15:0];

  logic [18:0] rem_frame;
  assign rem_frame = {3'd0, refresh_r} - total_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      mcsps_pkg::ST_IDLE: if (q_valid) st_nxt = mcsps_pkg::ST_CALC;
      mcsps_pkg::ST_CALC: begin
        if (cmd_r.op == mcsps_pkg::OP_ANGLE) st_nxt = mcsps_pkg::ST_DIV;
        else if (cmd_r.op == mcsps_pkg::OP_US) st_nxt = mcsps_pkg::ST_TICK;
        else st_nxt = mcsps_pkg::ST_DONE;
      end
      mcsps_pkg::ST_DIV: if (!div_first_r) st_nxt = mcsps_pkg::ST_TICK;
      mcsps_pkg::ST_TICK: st_nxt = mcsps_pkg::ST_DONE;
      mcsps_pkg::ST_DONE: if (!ovalid_r || res_ready) st_nxt = mcsps_pkg::ST_IDLE;
      default: st_nxt = mcsps_pkg::ST_IDLE;
    endcase
  end

  assign q_ready   = st_r == mcsps_pkg::ST_IDLE;
  assign res_valid = ovalid_r;
  assign res_data  = out_r;

  logic [7:0]  ang;
  logic [11:0] diff;
  assign ang  = (cmd_r.value > 12'd180) ? 8'd180 : cmd_r.value[7:0];
  // limits from attach always give max > min
  assign diff = max_r[ch] - min_r[ch];

  // divide by 180: drop two bits, then reciprocal multiply by 1/45
  logic [35:0] qprod;
  assign qprod = {18'd0, num_r[19:2]} * {18'd0, mcsps_pkg::RECIP45};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mcsps_pkg::ST_IDLE;
      active_r <= '0;
      total_r <= '0;
      idle_slot_r <= 1'b1;
      slot_r <= 3'd0;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == mcsps_pkg::ST_DONE && (!ovalid_r || res_ready)) ovalid_r <= 1'b1;
      else if (res_ready) ovalid_r <= 1'b0;
      case (st_r)
        mcsps_pkg::ST_IDLE: if (q_valid) begin
          cmd_r <= q_data;
          res_r <= '0;
        end
        mcsps_pkg::ST_CALC: begin
          case (cmd_r.op)
            mcsps_pkg::OP_ATTACH: begin
              if (att_ok) begin
                min_r[att_ch] <= mcsps_pkg::quantize(12'(mcsps_pkg::MIN_PULSE_US),
                                                     cmd_r.min_us);
                max_r[att_ch] <= mcsps_pkg::quantize(12'(mcsps_pkg::MAX_PULSE_US),
                                                     cmd_r.max_us);
                res_r.assigned_channel <= att_ch;
                // prod for default pulse, untrimmed; ticks applied in DONE, TICK is skipped
                us_r <= 13'(mcsps_pkg::DEFAULT_PULSE_US);
              end else res_r.status <= 1'b1;
              prod_r <= 32'(cpu_r) * 32'(mcsps_pkg::DEFAULT_PULSE_US);
            end
            mcsps_pkg::OP_DETACH: if (active_r[ch]) begin
              total_r <= total_r - {3'd0, ticks_r[ch]};
              active_r[ch] <= 1'b0;
            end
            mcsps_pkg::OP_ANGLE: begin
              num_r <= {12'd0, ang} * {8'd0, diff};
              div_first_r <= 1'b1;
            end
            mcsps_pkg::OP_US: us_r <= {1'b0, cmd_r.value};
            mcsps_pkg::OP_COMPARE: begin
              res_r.compare_valid <= 1'b1;
              if (!idle_slot_r) begin
                res_r.low_valid <= 1'b1;
                res_r.low_channel <= slot_r;
              end
              if (next_found) begin
                res_r.high_valid <= 1'b1;
                res_r.high_channel <= next_ch;
                res_r.compare_value <= cmd_r.timer_count + ticks_r[next_ch];
                slot_r <= next_ch;
                idle_slot_r <= 1'b0;
              end else begin
                idle_slot_r <= 1'b1;
                if (total_r > {3'd0, refresh_r}) begin
                  res_r.frame_underflow <= 1'b1;
                  res_r.compare_value <= cmd_r.timer_count;
                end else res_r.compare_value <= cmd_r.timer_count + rem_frame[15:0];
              end
            end
            default: ;
          endcase
        end
        mcsps_pkg::ST_DIV: begin
          // quotient first, then add the lower limit
          if (div_first_r) begin
            quo_r <= qprod[34:23];
            div_first_r <= 1'b0;
          end else begin
            us_r <= {1'b0, min_r[ch]} + {1'b0, quo_r};
          end
        end
        mcsps_pkg::ST_TICK: prod_r <= 32'(cpu_r) * 32'(trimmed);
        mcsps_pkg::ST_DONE: if (!ovalid_r || res_ready) begin
          out_r <= res_r;
          if (cmd_r.op == mcsps_pkg::OP_ATTACH && !res_r.status) begin
            ticks_r[res_r.assigned_channel] <= new_ticks;
            active_r[res_r.assigned_channel] <= 1'b1;
            total_r <= total_r + {3'd0, new_ticks} -
                       (active_r[res_r.assigned_channel] ?
                        {3'd0, ticks_r[res_r.assigned_channel]} : 19'd0);
          end else if (cmd_r.op == mcsps_pkg::OP_ANGLE || cmd_r.op == mcsps_pkg::OP_US) begin
            ticks_r[ch] <= new_ticks;
            if (active_r[ch]) total_r <= total_r - {3'd0, ticks_r[ch]} + {3'd0, new_ticks};
          end
        end
        default: ;
      endcase
    end
  end
endmodule

/* rtl/multi_channel_servo_pulse_sequencer_top.sv */
// Top level of the servo pulse sequencer: config registers, front end, queue, engine.
// Depends on mcsps_pkg, mcsps_front, mcsps_queue, mcsps_back.
`timescale 1ns / 1ps
// Eight servo channels share one compare timer. Attach, detach, angle and
// microsecond writes update the channel table; each compare event ends the
// running pulse, starts the next active channel and returns the next compare
// time, or the rest of the frame once the last channel is done. One result
// item comes out for every input item, in order. The engine steps through
// idle, calc and done for attach, detach, compare and unknown codes; a
// microsecond write adds a tick state (tick multiply), and an angle write
// also a divide state (divide by 180 by reciprocal multiply). It holds one
// item at a time and takes the next once the result is in the output register.
// A two-entry queue sits between input and engine and the result sits in its
// own output register, so input keeps flowing while a result waits; in_tready
// drops once both queue entries are full.
// Config writes are taken any cycle; write only when idle.
module multi_channel_servo_pulse_sequencer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [15:0]                 cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // operation, channel, auto_channel, min_us, max_us, value, timer_count
  input  logic [mcsps_pkg::IN_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // status, assigned_channel, low_valid, low_channel, high_valid,
  // high_channel, compare_valid, compare_value, frame_underflow
  output logic [mcsps_pkg::OUT_W-1:0] out_tdata
);
  logic [15:0] refresh_r;
  logic [5:0]  trim_r;
  logic [7:0]  cpu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_r <= 16'd40000;
      trim_r <= 6'd2;
      cpu_r <= 8'd16;
    end else if (cfg_we) begin
      case (mcsps_pkg::reg_idx_t'(cfg_index))
        mcsps_pkg::REG_REFRESH: refresh_r <= cfg_wdata;
        mcsps_pkg::REG_TRIM:    trim_r <= cfg_wdata[5:0];
        mcsps_pkg::REG_CPU:     cpu_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic            f_valid, f_ready, b_valid, b_ready;
  mcsps_pkg::cmd_t f_data, b_data;
  mcsps_pkg::res_t r;

  mcsps_front u_front (
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  mcsps_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  mcsps_back u_back (
    .clk(clk), .rst_n(rst_n),
    .refresh_r(refresh_r), .trim_r(trim_r), .cpu_r(cpu_r),
    .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .res_valid(out_tvalid), .res_ready(out_tready), .res_data(r)
  );

  assign out_tdata = {2'b00, r.frame_underflow, r.compare_value, r.compare_valid,
                      r.high_channel, r.high_valid, r.low_channel, r.low_valid,
                      r.assigned_channel, r.status};
endmodule
